// ===== design/chm_pkg.sv =====
// Shared types and constants for the monotone chain hull block.
`timescale 1ns / 1ps
package chm_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SmallSet = 3;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Cross product sign test: true when (a-o) x (b-o) <= 0.
  typedef logic signed [CoordW:0] diff_t;
  typedef logic signed [2*CoordW+1:0] prod_t;
endpackage

// ===== design/chm_cross.sv =====
// Two-stage cross product unit: multiply, register, subtract and compare.
`timescale 1ns / 1ps
module chm_cross (
  input  logic           clk,
  input  chm_pkg::point_t o,
  input  chm_pkg::point_t a,
  input  chm_pkg::point_t b,
  output logic           non_left
);
  import chm_pkg::*;
  diff_t ax, ay, bx, by;
  prod_t p1_r, p2_r;
  prod_t p1_nxt, p2_nxt;
  logic signed [2*CoordW+2:0] d;
  always_comb begin
    ax = diff_t'(a.x) - diff_t'(o.x);
    ay = diff_t'(a.y) - diff_t'(o.y);
    bx = diff_t'(b.x) - diff_t'(o.x);
    by = diff_t'(b.y) - diff_t'(o.y);
    p1_nxt = prod_t'(ax) * prod_t'(by);
    p2_nxt = prod_t'(ay) * prod_t'(bx);
  end
  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end
  assign d = (2*CoordW+3)'(p1_r) - (2*CoordW+3)'(p2_r);
  assign non_left = (d[2*CoordW+2] == 1'b1) || (d == '0);
endmodule

// ===== design/convex_hull_monotone_chain_top.sv =====
// Top level of the monotone chain convex hull block.
`timescale 1ns / 1ps
// Load: one word a cycle; busy stays low until a word with in_last_point arrives.
// Sort: insertion sort of the point store, one shift write per step (n^2 worst case).
// Chain: read, two stack reads, multiply, decide per point (read and decide alone while the
// chain is too short to test); a pop rereads the top. Emit: one vertex a cycle from slot 0.
// Throughput: one set at a time; the receiver cannot stall out_valid.
// Reset: synchronous active-low rst_n empties the store and returns to load.
module convex_hull_monotone_chain_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  chm_pkg::coord_t        in_point_x,
  input  chm_pkg::coord_t        in_point_y,
  input  logic                   in_last_point,
  output logic                   out_valid,
  output chm_pkg::coord_t        out_hull_x,
  output chm_pkg::coord_t        out_hull_y,
  output logic                   out_last_vertex
);
  import chm_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int SD = 2 * MAX_POINTS + 1;
  localparam int SW = $clog2(SD + 1);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [11:0] {
    S_LOAD   = 12'b000000000001,
    S_SMALL  = 12'b000000000010,
    S_SRD    = 12'b000000000100, // read key point i
    S_SCMP   = 12'b000000001000, // read point j-1
    S_SCHK   = 12'b000000010000, // compare, shift or place
    S_CRD    = 12'b000000100000, // read next chain point
    S_CTOP   = 12'b000001000000, // read stack[top-1]
    S_CTOP2  = 12'b000010000000, // read stack[top-2]
    S_CMUL   = 12'b000100000000, // multiply stage
    S_CDEC   = 12'b001000000000, // pop or push
    S_EMIT   = 12'b010000000000,
    S_EMRD   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // Point store and hull stack memories.
  point_t pmem [MAX_POINTS];
  point_t smem [SD];
  point_t prd_r, srd_r;
  logic [AW-1:0] pra, pwa;
  point_t pwd;
  logic pwe;
  logic [SW-1:0] sra, swa;
  point_t swd;
  logic swe;

  // Forward a same-cycle write so a one-point set reads back its own word.
  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    if (pwe && (pwa == pra)) prd_r <= pwd;
    else prd_r <= pmem[pra];
    if (swe) smem[swa] <= swd;
    srd_r <= smem[sra];
  end

  logic [CW-1:0] cnt_r, cnt_nxt;       // points stored
  logic [CW-1:0] i_r, i_nxt;           // outer index
  logic [CW-1:0] j_r, j_nxt;           // insertion slot
  logic [SW-1:0] top_r, top_nxt;
  logic [SW-1:0] lim_r, lim_nxt;
  logic          upper_r, upper_nxt;   // building the upper chain
  point_t key_r, key_nxt;              // point being sorted or pushed
  point_t a_r, a_nxt;                  // stack[top-1]
  point_t o_r, o_nxt;                  // stack[top-2]
  logic [CW-1:0] ecnt_r, ecnt_nxt;     // vertices to emit
  logic          ov_r, ov_nxt;
  point_t        op_r, op_nxt;
  logic          ol_r, ol_nxt;
  logic          non_left;

  chm_cross u_cross (.clk(clk), .o(o_r), .a(a_r), .b(key_r), .non_left(non_left));

  logic key_before;
  assign key_before = (key_r.x < prd_r.x) || ((key_r.x == prd_r.x) && (key_r.y < prd_r.y));

  assign busy = (state_r != S_LOAD);
  assign out_valid = ov_r;
  assign out_hull_x = op_r.x;
  assign out_hull_y = op_r.y;
  assign out_last_vertex = ol_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r;
    top_nxt = top_r; lim_nxt = lim_r; upper_nxt = upper_r;
    key_nxt = key_r; a_nxt = a_r; o_nxt = o_r; ecnt_nxt = ecnt_r;
    ov_nxt = 1'b0; op_nxt = op_r; ol_nxt = 1'b0;
    pra = '0; pwa = '0; pwd = key_r; pwe = 1'b0;
    sra = '0; swa = top_r; swd = key_r; swe = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          // store the word unless full
          if (cnt_r < CW'(MAX_POINTS)) begin
            pwe = 1'b1; pwa = AW'(cnt_r);
            pwd = '{x: in_point_x, y: in_point_y};
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_point) begin
            if (cnt_nxt <= CW'(SmallSet)) begin
              i_nxt = '0; state_nxt = S_SMALL; pra = '0;
            end else begin
              i_nxt = CW'(1); state_nxt = S_SRD;
            end
          end
        end
      end
      S_SMALL: begin
        // prd_r holds point i; emit it and read the next
        ov_nxt = 1'b1; op_nxt = prd_r;
        ol_nxt = (i_r + 1'b1 == cnt_r);
        i_nxt = i_r + 1'b1;
        pra = AW'(i_r + 1'b1);
        if (i_r + 1'b1 == cnt_r) begin
          cnt_nxt = '0; state_nxt = S_LOAD;
        end
      end
      S_SRD: begin
        if (i_r == cnt_r) begin
          i_nxt = '0; top_nxt = '0; upper_nxt = 1'b0;
          state_nxt = S_CRD;
        end else begin
          pra = AW'(i_r); j_nxt = i_r; state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (j_r == i_r) key_nxt = prd_r;
        if (j_r == '0) begin
          pwe = 1'b1; pwa = '0; pwd = (j_r == i_r) ? prd_r : key_r;
          i_nxt = i_r + 1'b1; state_nxt = S_SRD;
        end else begin
          pra = AW'(j_r - 1'b1); state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        pwe = 1'b1; pwa = AW'(j_r);
        if (key_before) begin
          pwd = prd_r; j_nxt = j_r - 1'b1; state_nxt = S_SCMP;
        end else begin
          pwd = key_r; i_nxt = i_r + 1'b1; state_nxt = S_SRD;
        end
      end
      S_CRD: begin
        // lower chain walks i=0..n-1, upper walks n-2 down to 0
        pra = AW'(i_r); state_nxt = S_CTOP;
      end
      S_CTOP: begin
        key_nxt = prd_r;
        sra = top_r - 1'b1; state_nxt = S_CTOP2;
        if (upper_r ? (top_r < lim_r) : (top_r < SW'(2))) state_nxt = S_CDEC;
      end
      S_CTOP2: begin
        a_nxt = srd_r; sra = top_r - SW'(2); state_nxt = S_CMUL;
      end
      S_CMUL: begin
        o_nxt = srd_r; state_nxt = S_EMRD;
      end
      S_EMRD: begin
        // product stage registered; result on next cycle
        state_nxt = S_CDEC;
      end
      S_CDEC: begin
        if ((upper_r ? (top_r >= lim_r) : (top_r >= SW'(2))) && non_left) begin
          top_nxt = top_r - 1'b1;
          // reload the two new top entries
          sra = top_r - SW'(2); state_nxt = S_CTOP2;
          a_nxt = o_r;
          if (upper_r ? (top_r - 1'b1 < lim_r) : (top_r - 1'b1 < SW'(2))) state_nxt = S_CDEC;
        end else begin
          swe = 1'b1; swa = top_r; swd = key_r;
          top_nxt = top_r + 1'b1;
          state_nxt = S_CRD;
          if (!upper_r) begin
            if (i_r + 1'b1 == cnt_r) begin
              upper_nxt = 1'b1; lim_nxt = top_r + SW'(2);
              i_nxt = cnt_r - CW'(2);
            end else i_nxt = i_r + 1'b1;
          end else if (i_r == '0) begin
            ecnt_nxt = (top_r > SW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(top_r);
            i_nxt = '0; state_nxt = S_EMIT; sra = '0;
          end else i_nxt = i_r - 1'b1;
        end
      end
      S_EMIT: begin
        ov_nxt = 1'b1; op_nxt = srd_r;
        ol_nxt = (i_r + 1'b1 == ecnt_r);
        i_nxt = i_r + 1'b1;
        sra = SW'(i_r + 1'b1);
        if (i_r + 1'b1 == ecnt_r) begin
          cnt_nxt = '0; state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; top_r <= '0; ov_r <= 1'b0; ol_r <= 1'b0;
      upper_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; top_r <= top_nxt; ov_r <= ov_nxt;
      ol_r <= ol_nxt; upper_r <= upper_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; lim_r <= lim_nxt; key_r <= key_nxt;
    a_r <= a_nxt; o_r <= o_nxt; ecnt_r <= ecnt_nxt; op_r <= op_nxt;
  end
endmodule

// ===== tb/hull_checker.sv =====
// Checker for the monotone chain hull block: predicts hull vertices and compares.
`timescale 1ns / 1ps
module hull_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  chm_pkg::coord_t in_point_x,
  input  chm_pkg::coord_t in_point_y,
  input  logic            in_last_point,
  input  logic            out_valid,
  input  chm_pkg::coord_t out_hull_x,
  input  chm_pkg::coord_t out_hull_y,
  input  logic            out_last_vertex,
  output int              fail_count,
  output int              pending_vertices
);
  import chm_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_t;

  point_t  loaded_pts[MAX_POINTS];
  int      loaded_cnt;
  vertex_t hull_queue[$];

  function automatic longint cross_turn(point_t o, point_t a, point_t b);
    longint ax, ay, bx, by;
    ax = longint'(a.x) - longint'(o.x);
    ay = longint'(a.y) - longint'(o.y);
    bx = longint'(b.x) - longint'(o.x);
    by = longint'(b.y) - longint'(o.y);
    return ax * by - ay * bx;
  endfunction

  function automatic bit pt_less(point_t a, point_t b);
    return (a.x < b.x) || (a.x == b.x && a.y < b.y);
  endfunction

  // Sort the stored set, build both chains, queue the vertices.
  task automatic predict_hull();
    point_t srt[MAX_POINTS];
    point_t stk[2*MAX_POINTS+1];
    point_t v;
    int n, j, top, lim, cnt;
    vertex_t e;
    n = loaded_cnt;
    if (n <= SmallSet) begin
      for (int i = 0; i < n; i++) begin
        e.x = loaded_pts[i].x; e.y = loaded_pts[i].y; e.last = (i == n - 1);
        hull_queue = {hull_queue, e};
      end
      return;
    end
    for (int i = 0; i < n; i++) srt[i] = loaded_pts[i];
    for (int i = 1; i < n; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && pt_less(v, srt[j-1])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    top = 0;
    for (int i = 0; i < n; i++) begin
      while (top >= 2 && cross_turn(stk[top-2], stk[top-1], srt[i]) <= 0) top--;
      stk[top++] = srt[i];
    end
    lim = top + 1;
    for (int i = n - 1; i > 0; i--) begin
      while (top >= lim && cross_turn(stk[top-2], stk[top-1], srt[i-1]) <= 0) top--;
      stk[top++] = srt[i-1];
    end
    cnt = top - 1;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    for (int i = 0; i < cnt; i++) begin
      e.x = stk[i].x; e.y = stk[i].y; e.last = (i == cnt - 1);
      hull_queue = {hull_queue, e};
    end
  endtask

  always @(posedge clk) begin
    vertex_t exp_v;
    point_t  p;
    if (!rst_n) begin
      loaded_cnt = 0;
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (hull_queue.size() == 0) begin
          $display("%0t: unexpected vertex x=%0d y=%0d last=%0b", $time,
                   out_hull_x, out_hull_y, out_last_vertex);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = hull_queue.pop_front();
          if (exp_v.x !== out_hull_x || exp_v.y !== out_hull_y ||
              exp_v.last !== out_last_vertex) begin
            $display("%0t: vertex mismatch expected x=%0d y=%0d last=%0b,",
                     $time, exp_v.x, exp_v.y, exp_v.last,
                     " got x=%0d y=%0d last=%0b",
                     out_hull_x, out_hull_y, out_last_vertex);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        p.x = in_point_x;
        p.y = in_point_y;
        if (loaded_cnt < MAX_POINTS) begin
          loaded_pts[loaded_cnt] = p;
          loaded_cnt = loaded_cnt + 1;
        end
        if (in_last_point) begin
          predict_hull();
          loaded_cnt = 0;
        end
      end
    end
    pending_vertices = hull_queue.size();
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the monotone chain hull block: stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import chm_pkg::*;

  localparam int MaxPts = 64;
  localparam longint CycleLimit = 1000000;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic   in_last_point = 1'b0;
  logic   out_valid;
  coord_t out_hull_x, out_hull_y;
  logic   out_last_vertex;
  int     fail_count, pending_vertices;
  longint cycle_cnt = 0;

  always #1 clk = ~clk;

  convex_hull_monotone_chain_top #(.MAX_POINTS(MaxPts)) uut (.*);

  hull_checker #(.MAX_POINTS(MaxPts)) chk (.*);

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one word and hold it until busy is seen low. Gaps come between bursts,
  // and the valid stays up across back-to-back words without a low pulse.
  task automatic send_point(coord_t x, coord_t y, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start once the set is closed so the block can crunch undisturbed.
  task automatic idle_line();
    start <= 1'b0;
    in_last_point <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_set(int n, int span);
    coord_t x, y;
    for (int i = 0; i < n; i++) begin
      if (span == 0) begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
      end else begin
        x = coord_t'($urandom_range(0, 2*span) - span);
        y = coord_t'($urandom_range(0, 2*span) - span);
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single, pair, triple kept in arrival order.
    send_point(16'sh7fff, -16'sh8000, 1'b1);
    send_point(-16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(-3, 2, 1'b0);
    send_point(1, -7, 1'b1);
    // Extreme corners with a collinear midpoint and a duplicate.
    send_point(-16'sh8000, -16'sh8000, 1'b0);
    send_point(16'sh7fff, -16'sh8000, 1'b0);
    send_point(0, -16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(-16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(0, 0, 1'b1);
    // All points on one line, and all identical.
    for (int i = 0; i < 5; i++) send_point(coord_t'(i*3), coord_t'(i*2), i == 4);
    for (int i = 0; i < 4; i++) send_point(-1, -1, i == 3);
    idle_line();

    // Random sets: mostly small, some full, some overflowing the store.
    while (cycle_cnt < CycleLimit / 2 && n < 430) begin
      int sz, kind;
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      kind = $urandom_range(0, 3);
      send_set(sz, kind == 0 ? 0 : (kind == 1 ? 4 : 1000));
      n += sz;
      idle_line();
    end

    while (pending_vertices != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_vertices == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
